// ===== design/msdt_pkg.sv =====
// Shared types, codes and constants of the multi-slot deadline timer.
package msdt_pkg;

  localparam int unsigned TIMER_SLOTS_DEF = 16;

  localparam int unsigned TIME_W    = 64;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SLOT_IN_W = 4;

  localparam int unsigned S_TDATA_W = 200;
  localparam int unsigned M_TDATA_W = 72;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_FIND,
    ST_ADD_OK,
    ST_ADD_FULL,
    ST_CANCEL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_UPD,
    ST_SUMMARY
  } msdt_state_e;

  typedef struct packed {
    logic                in_ready;
    logic                in_load;
    logic                idx_clr;
    logic                idx_inc;
    logic                add_wr;
    logic                rearm_wr;
    logic                slot_free;
    logic                cancel_free;
    logic                eval;
    logic                best_init;
    logic                best_upd;
    logic                out_load;
    logic [KIND_W-1:0]   out_kind;
    logic [STATUS_W-1:0] out_status;
    logic                out_last;
  } msdt_cmd_t;

  typedef struct packed {
    logic            in_valid;
    logic [OP_W-1:0] in_op;
    logic            idx_valid;
    logic            idx_last;
    logic            fired;
    logic            per_zero;
    logic            cancel_hit;
    logic            out_free;
  } msdt_sts_t;

endpackage

// ===== design/msdt_ctrl.sv =====
// Controller state machine that sequences add, cancel and scan requests.
module msdt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msdt_pkg::msdt_sts_t sts_i,
  output msdt_pkg::msdt_cmd_t cmd_o
);
  import msdt_pkg::*;

  msdt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sts_i.in_valid) begin
          case (sts_i.in_op)
            OP_ADD:    state_d = ST_ADD_FIND;
            OP_CANCEL: state_d = ST_CANCEL;
            OP_SCAN:   state_d = ST_SCAN_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_FIND: begin
        if (!sts_i.idx_valid) begin
          state_d = ST_ADD_OK;
        end else if (sts_i.idx_last) begin
          state_d = ST_ADD_FULL;
        end
      end
      ST_ADD_OK, ST_ADD_FULL, ST_CANCEL, ST_SUMMARY: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        if (sts_i.idx_valid) begin
          state_d = ST_SCAN_CHK;
        end else if (sts_i.idx_last) begin
          state_d = ST_SUMMARY;
        end
      end
      ST_SCAN_CHK: state_d = ST_SCAN_UPD;
      ST_SCAN_UPD: begin
        if (!sts_i.fired || sts_i.out_free) begin
          state_d = sts_i.idx_last ? ST_SUMMARY : ST_SCAN_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.in_load   = 1'b1;
          cmd_o.idx_clr   = 1'b1;
          cmd_o.best_init = 1'b1;
        end
      end
      ST_ADD_FIND: begin
        cmd_o.idx_inc = sts_i.idx_valid && !sts_i.idx_last;
      end
      ST_ADD_OK: begin
        if (sts_i.out_free) begin
          cmd_o.add_wr     = 1'b1;
          cmd_o.out_load   = 1'b1;
          cmd_o.out_kind   = KIND_ADD;
          cmd_o.out_status = STATUS_OK;
          cmd_o.out_last   = 1'b1;
        end
      end
      ST_ADD_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_kind   = KIND_ADD;
          cmd_o.out_status = STATUS_FULL;
          cmd_o.out_last   = 1'b1;
        end
      end
      ST_CANCEL: begin
        if (sts_i.out_free) begin
          cmd_o.cancel_free = sts_i.cancel_hit;
          cmd_o.out_load    = 1'b1;
          cmd_o.out_kind    = KIND_CANCEL;
          cmd_o.out_status  = sts_i.cancel_hit ? STATUS_OK : STATUS_EMPTY;
          cmd_o.out_last    = 1'b1;
        end
      end
      ST_SCAN_RD: begin
        cmd_o.idx_inc = !sts_i.idx_valid && !sts_i.idx_last;
      end
      ST_SCAN_CHK: begin
        cmd_o.eval = 1'b1;
      end
      ST_SCAN_UPD: begin
        if (!sts_i.fired) begin
          cmd_o.best_upd = 1'b1;
          cmd_o.idx_inc  = !sts_i.idx_last;
        end else if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_kind   = KIND_FIRED;
          cmd_o.out_status = STATUS_OK;
          cmd_o.slot_free  = sts_i.per_zero;
          cmd_o.rearm_wr   = !sts_i.per_zero;
          cmd_o.best_upd   = !sts_i.per_zero;
          cmd_o.idx_inc    = !sts_i.idx_last;
        end
      end
      ST_SUMMARY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_kind   = KIND_SUMMARY;
          cmd_o.out_status = STATUS_OK;
          cmd_o.out_last   = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== design/msdt_datapath.sv =====
// Datapath holding the slot table, the scan arithmetic and the result register.
module msdt_datapath #(
  parameter int unsigned TIMER_SLOTS = msdt_pkg::TIMER_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  msdt_pkg::msdt_cmd_t              cmd_i,
  output msdt_pkg::msdt_sts_t              sts_o,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [msdt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic [msdt_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [msdt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic [msdt_pkg::KIND_W-1:0]      m_axis_tuser,
  output logic                             m_axis_tlast
);
  import msdt_pkg::*;

  localparam int unsigned SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(TIMER_SLOTS - 1);

  logic [TIME_W-1:0]    dl_in_q, per_in_q, now_q;
  logic [SLOT_IN_W-1:0] slot_in_q;
  logic [SLOT_W-1:0]    idx_q;
  logic [TIMER_SLOTS-1:0] valid_q;

  logic [TIME_W-1:0] dl_mem [TIMER_SLOTS];
  logic [TIME_W-1:0] per_mem [TIMER_SLOTS];
  logic [TIME_W-1:0] dl_rd_q, per_rd_q;

  logic              fired_q, per_zero_q;
  logic [TIME_W-1:0] sum_q, best_q, cand;
  logic [TIME_W:0]   sum_full;

  logic [SLOT_W-1:0] cancel_idx;
  logic              cancel_range, cancel_hit;

  logic                 out_valid_q, out_last_q, out_free;
  logic [KIND_W-1:0]    out_kind_q;
  logic [SLOT_IN_W-1:0] out_slot_q, out_slot_d;
  logic [STATUS_W-1:0]  out_status_q;
  logic [TIME_W-1:0]    out_next_q, out_next_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      dl_in_q   <= s_axis_tdata[63:0];
      per_in_q  <= s_axis_tdata[127:64];
      slot_in_q <= s_axis_tdata[131:128];
      now_q     <= s_axis_tdata[195:132];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + SLOT_W'(1);
    end
  end

  assign cancel_idx   = SLOT_W'(slot_in_q);
  assign cancel_range = (32'(slot_in_q) < TIMER_SLOTS);
  assign cancel_hit   = cancel_range && valid_q[cancel_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (cmd_i.add_wr) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (cmd_i.slot_free) begin
        valid_q[idx_q] <= 1'b0;
      end
      if (cmd_i.cancel_free) begin
        valid_q[cancel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_wr) begin
      dl_mem[idx_q]  <= dl_in_q;
      per_mem[idx_q] <= per_in_q;
    end else if (cmd_i.rearm_wr) begin
      dl_mem[idx_q] <= sum_q;
    end
    dl_rd_q  <= dl_mem[idx_q];
    per_rd_q <= per_mem[idx_q];
  end

  assign sum_full = {1'b0, dl_rd_q} + {1'b0, per_rd_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      fired_q    <= (dl_rd_q <= now_q);
      per_zero_q <= (per_rd_q == '0);
      sum_q      <= sum_full[TIME_W] ? '1 : sum_full[TIME_W-1:0];
    end
  end

  assign cand = fired_q ? sum_q : dl_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.best_init) begin
      best_q <= '1;
    end else if (cmd_i.best_upd && (cand < best_q)) begin
      best_q <= cand;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    case (cmd_i.out_kind)
      KIND_ADD:    out_slot_d = (cmd_i.out_status == STATUS_OK) ? SLOT_IN_W'(idx_q) : '0;
      KIND_CANCEL: out_slot_d = slot_in_q;
      KIND_FIRED:  out_slot_d = SLOT_IN_W'(idx_q);
      default:     out_slot_d = '0;
    endcase
    out_next_d = (cmd_i.out_kind == KIND_SUMMARY) ? best_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q   <= cmd_i.out_kind;
      out_slot_q   <= out_slot_d;
      out_status_q <= cmd_i.out_status;
      out_next_q   <= out_next_d;
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign s_axis_tready = cmd_i.in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_next_q, out_status_q, out_slot_q};

  always_comb begin
    sts_o            = '0;
    sts_o.in_valid   = s_axis_tvalid;
    sts_o.in_op      = s_axis_tuser;
    sts_o.idx_valid  = valid_q[idx_q];
    sts_o.idx_last   = (idx_q == IDX_LAST);
    sts_o.fired      = fired_q;
    sts_o.per_zero   = per_zero_q;
    sts_o.cancel_hit = cancel_hit;
    sts_o.out_free   = out_free;
  end

  a_add_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_wr |-> !valid_q[idx_q])
    else $error("Add request overwrote a slot that was in use.");

  a_out_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("Result register loaded while a result was still pending.");

  a_best_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.best_upd |=> (best_q <= $past(best_q)))
    else $error("Earliest deadline rose during a scan.");

  a_cancel_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cancel_free |=> !valid_q[$past(cancel_idx)])
    else $error("Cancelled slot is still marked as in use.");

endmodule

// ===== design/multi_slot_deadline_timer.sv =====
// Top level of the multi-slot deadline timer: controller and datapath.
// The block keeps a table of TIMER_SLOTS timers, each an absolute 64-bit deadline with a
// rearm period (zero for one-shot). Requests are handled one at a time. An add request
// walks the slot valid bits one per cycle to find the lowest free slot. A scan request
// walks the table through the single read port of the deadline and period memories,
// whose read data is registered: an empty slot is only checked for its valid bit, and an
// occupied slot goes through read, compare and add, and write back. The scan closes with
// a summary result. A request waits whenever it has a result to load and the result
// register is still held by the downstream side. A new request is taken as soon as the
// previous one has placed its final result in the result register.
module multi_slot_deadline_timer #(
  parameter int unsigned TIMER_SLOTS = msdt_pkg::TIMER_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // deadline[63:0], period[127:64], slot[131:128], now_time[195:132]
  input  logic [msdt_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // operation[1:0]
  input  logic [msdt_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // slot_id[3:0], status[5:4], next_deadline[69:6]
  output logic [msdt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [msdt_pkg::KIND_W-1:0]    m_axis_tuser,
  output logic                           m_axis_tlast
);
  import msdt_pkg::*;

  msdt_cmd_t cmd;
  msdt_sts_t sts;

  msdt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  msdt_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
